FILE: hw/rtl/abs_pkg.sv
// Shared types, codes and defaults of the adaptive beacon scheduler.
package abs_pkg;

	localparam int TIME_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int IV_W          = 20;

	// Configuration register indexes
	localparam logic [2:0] CFG_MODE       = 3'd0;
	localparam logic [2:0] CFG_MIN_IV     = 3'd1;
	localparam logic [2:0] CFG_MAX_IV     = 3'd2;
	localparam logic [2:0] CFG_STATIC_IV  = 3'd3;
	localparam logic [2:0] CFG_NBR_THR    = 3'd4;
	localparam logic [2:0] CFG_CONT_THR   = 3'd5;
	localparam logic [2:0] CFG_REF_SPEED  = 3'd6;
	localparam logic [2:0] CFG_FIRST_WAIT = 3'd7;

	// Scheduling modes
	localparam logic [1:0] MODE_STATIC = 2'd0;
	localparam logic [1:0] MODE_DENS   = 2'd1;
	localparam logic [1:0] MODE_COMB   = 2'd2;

	// Reset values of the registers
	localparam logic [IV_W-1:0] RST_MIN_IV     = 20'd1000;
	localparam logic [IV_W-1:0] RST_MAX_IV     = 20'd5000;
	localparam logic [IV_W-1:0] RST_STATIC_IV  = 20'd250;
	localparam logic [7:0]      RST_NBR_THR    = 8'd15;
	localparam logic [IV_W-1:0] RST_CONT_THR   = 20'd20000;
	localparam logic [15:0]     RST_REF_SPEED  = 16'd15;
	localparam logic [IV_W-1:0] RST_FIRST_WAIT = 20'd2500;

	// Divisor of the weighted score sum
	localparam logic [IV_W-1:0] COMB_DIV = 20'd10;

	// Datapath operations
	typedef enum logic [3:0] {
		OP_IDLE,
		OP_SQUARE,
		OP_DENS,
		OP_CONT,
		OP_SQRT,
		OP_MOB,
		OP_COMB,
		OP_FQ,
		OP_SCALE,
		OP_JIT,
		OP_DONE
	} abs_op_t;

	typedef struct packed {
		logic    accept;
		logic    start;
		logic    commit;
		abs_op_t op;
	} abs_cmd_t;

	typedef struct packed {
		logic       div_done;
		logic       sqrt_done;
		logic       out_free;
		logic [1:0] mode;
	} abs_status_t;

endpackage

FILE: hw/rtl/abs_ctrl.sv
// Sequencer of the beacon scheduler: steps the datapath through one check.
module abs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  abs_pkg::abs_status_t status,
	output abs_pkg::abs_cmd_t    cmd
);
	import abs_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_LOAD  = 11'b00000000010,
		S_DENS  = 11'b00000000100,
		S_CONT  = 11'b00000001000,
		S_SQRT  = 11'b00000010000,
		S_MOB   = 11'b00000100000,
		S_COMB  = 11'b00001000000,
		S_FQ    = 11'b00010000000,
		S_SCALE = 11'b00100000000,
		S_JIT   = 11'b01000000000,
		S_DONE  = 11'b10000000000
	} state_t;

	state_t state_q, state_n;
	logic   first_q;
	logic   adaptive;

	assign adaptive = (status.mode == MODE_DENS) || (status.mode == MODE_COMB);
	assign in_stall = (state_q != S_IDLE);

	// Next state and command
	always_comb begin
		state_n    = state_q;
		cmd.accept = (state_q == S_IDLE) && in_valid;
		cmd.start  = first_q;
		cmd.commit = (state_q == S_DONE) && status.out_free;
		cmd.op     = OP_IDLE;
		unique case (state_q)
			S_IDLE: begin
				cmd.op = OP_IDLE;
				if (in_valid) state_n = S_LOAD;
			end
			S_LOAD: begin
				cmd.op  = OP_SQUARE;
				state_n = adaptive ? S_DENS : S_DONE;
			end
			S_DENS: begin
				cmd.op = OP_DENS;
				if (status.div_done) state_n = (status.mode == MODE_COMB) ? S_CONT : S_FQ;
			end
			S_CONT: begin
				cmd.op = OP_CONT;
				if (status.div_done) state_n = S_SQRT;
			end
			S_SQRT: begin
				cmd.op = OP_SQRT;
				if (status.sqrt_done) state_n = S_MOB;
			end
			S_MOB: begin
				cmd.op = OP_MOB;
				if (status.div_done) state_n = S_COMB;
			end
			S_COMB: begin
				cmd.op  = OP_COMB;
				state_n = S_FQ;
			end
			S_FQ: begin
				cmd.op  = OP_FQ;
				state_n = S_SCALE;
			end
			S_SCALE: begin
				cmd.op  = OP_SCALE;
				state_n = S_JIT;
			end
			S_JIT: begin
				cmd.op  = OP_JIT;
				state_n = S_DONE;
			end
			S_DONE: begin
				cmd.op = OP_DONE;
				if (status.out_free) state_n = S_IDLE;
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	// State register; start pulses on the first cycle of each state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			first_q <= 1'b0;
		end else begin
			state_q <= state_n;
			first_q <= (state_n != state_q);
		end
	end

endmodule

FILE: hw/rtl/abs_datapath.sv
// Datapath of the beacon scheduler: config, scores, shared divider, root, interval.
module abs_datapath #(
	parameter int TIME_BITS = abs_pkg::TIME_BITS_DEF,
	parameter int FRAC_BITS = abs_pkg::FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  abs_pkg::abs_cmd_t     cmd,
	output abs_pkg::abs_status_t  status,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [19:0]           cfg_data,
	input  logic [31:0]           now_time,
	input  logic [7:0]            neighbor_count,
	input  logic [31:0]           newest_contact,
	input  logic signed [15:0]    vel_x,
	input  logic signed [15:0]    vel_y,
	input  logic [15:0]           random_fraction,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  send_now,
	output logic [19:0]           next_check
);
	import abs_pkg::*;

	localparam int NW = IV_W + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);
	localparam int WB = (TIME_BITS > 32) ? TIME_BITS : 32;
	localparam int AW = (TIME_BITS > IV_W) ? TIME_BITS : IV_W;
	localparam int SW = FRAC_BITS + 4;
	localparam int QW = FRAC_BITS + 1;
	// Reciprocal of the weighted-sum divisor, exact for every sum below 2^SW
	localparam int DK = SW + 4;
	localparam int MW = DK - 2;
	localparam logic [63:0] DIV_M =
		((64'd1 << DK) + 64'(COMB_DIV) - 64'd1) / 64'(COMB_DIV);

	// Configuration registers and scheduler state
	logic [1:0]          mode_q;
	logic [IV_W-1:0]     min_q, max_q, static_q, cthr_q, wait_q;
	logic [7:0]          nthr_q;
	logic [15:0]         rspd_q;
	logic [TIME_BITS-1:0] last_q;

	// Captured item
	logic [TIME_BITS-1:0] now_q, newest_q;
	logic [7:0]           n_q;
	logic signed [15:0]   vx_q, vy_q;
	logic [15:0]          r_q;

	// Intermediate results
	logic [31:0]   sqx_q, sqy_q;
	logic [QW-1:0] dens_q, cont_q, mob_q, comb_q, fq_q;
	logic [15:0]   speed_q;
	logic [IV_W:0] bi_q;
	logic [21:0]   jit_q;

	// Output register
	logic            out_valid_q;
	logic            send_q;
	logic [IV_W-1:0] next_q;

	// Divider and root registers
	logic [NW-1:0]   dv_num_q;
	logic [IV_W-1:0] dv_den_q, dv_rem_q;
	logic [CW-1:0]   dv_cnt_q;
	logic            dv_busy_q, dv_done_q;
	logic [31:0]     sq_v_q;
	logic [17:0]     sq_rem_q;
	logic [15:0]     sq_root_q;
	logic [4:0]      sq_cnt_q;
	logic            sq_busy_q, sq_done_q;

	logic [WB-1:0]        now_ext, newest_ext;
	logic [TIME_BITS-1:0] now_t, newest_t, age, elapsed;
	logic [AW-1:0]        age_w;
	logic                 age_lt;
	logic [IV_W-1:0]      cont_diff;
	logic [QW-1:0]        one_c;
	logic [SW-1:0]        sum;
	logic [SW+MW-1:0]     prod_div;
	logic                 dv_load;
	logic [NW-1:0]        dv_num_ld;
	logic [IV_W-1:0]      dv_den_ld;
	logic [IV_W:0]        dv_rem_sh;
	logic [17:0]          sq_rem_sh, sq_trial;
	logic [QW-1:0]        score;
	logic [2*QW-1:0]      prod_sq;
	logic [QW+IV_W-1:0]   prod_sc;
	logic [IV_W-1:0]      span;
	logic [16:0]          jit_mul;
	logic [37:0]          prod_j;
	logic [IV_W-1:0]      interval;
	logic                 send_c;
	logic [IV_W-1:0]      next_c;
	logic                 adaptive;

	assign now_ext    = WB'(now_time);
	assign newest_ext = WB'(newest_contact);
	assign now_t      = now_ext[TIME_BITS-1:0];
	assign newest_t   = newest_ext[TIME_BITS-1:0];
	assign one_c      = QW'(1) << FRAC_BITS;

	// Contact age, clamped at zero
	assign age       = (newest_q > now_q) ? '0 : (now_q - newest_q);
	assign age_w     = AW'(age);
	assign age_lt    = age_w < AW'(cthr_q);
	assign cont_diff = cthr_q - age_w[IV_W-1:0];

	// Weighted score sum, divided by ten with a reciprocal multiply
	assign sum      = (SW'(dens_q) << 2) + SW'(3) * SW'(cont_q) + SW'(3) * SW'(one_c - mob_q);
	assign prod_div = sum * DIV_M[MW-1:0];

	// Divider operands per operation
	assign dv_load = cmd.start && (cmd.op == OP_DENS || cmd.op == OP_CONT ||
	                               cmd.op == OP_MOB);

	always_comb begin
		dv_num_ld = '0;
		dv_den_ld = '0;
		case (cmd.op)
			OP_DENS: begin
				dv_num_ld = NW'(n_q) << FRAC_BITS;
				dv_den_ld = IV_W'(nthr_q);
			end
			OP_CONT: begin
				dv_num_ld = NW'(cont_diff) << FRAC_BITS;
				dv_den_ld = cthr_q;
			end
			OP_MOB: begin
				dv_num_ld = NW'(speed_q) << FRAC_BITS;
				dv_den_ld = IV_W'(rspd_q);
			end
			default: begin
				dv_num_ld = '0;
				dv_den_ld = '0;
			end
		endcase
	end

	// Restoring divider step, one quotient bit per cycle
	assign dv_rem_sh = {dv_rem_q, dv_num_q[NW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_busy_q <= 1'b0;
			dv_done_q <= 1'b0;
			dv_cnt_q  <= '0;
		end else begin
			dv_done_q <= 1'b0;
			if (dv_load) begin
				dv_busy_q <= 1'b1;
				dv_cnt_q  <= CW'(NW);
			end else if (dv_busy_q) begin
				dv_cnt_q <= dv_cnt_q - CW'(1);
				if (dv_cnt_q == CW'(1)) begin
					dv_busy_q <= 1'b0;
					dv_done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dv_load) begin
			dv_num_q <= dv_num_ld;
			dv_den_q <= dv_den_ld;
			dv_rem_q <= '0;
		end else if (dv_busy_q) begin
			if (dv_rem_sh >= {1'b0, dv_den_q}) begin
				dv_rem_q <= IV_W'(dv_rem_sh - {1'b0, dv_den_q});
				dv_num_q <= {dv_num_q[NW-2:0], 1'b1};
			end else begin
				dv_rem_q <= dv_rem_sh[IV_W-1:0];
				dv_num_q <= {dv_num_q[NW-2:0], 1'b0};
			end
		end
	end

	// Integer square root, one result bit per cycle
	assign sq_rem_sh = {sq_rem_q[15:0], sq_v_q[31:30]};
	assign sq_trial  = {sq_root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_busy_q <= 1'b0;
			sq_done_q <= 1'b0;
			sq_cnt_q  <= '0;
		end else begin
			sq_done_q <= 1'b0;
			if (cmd.start && cmd.op == OP_SQRT) begin
				sq_busy_q <= 1'b1;
				sq_cnt_q  <= 5'd16;
			end else if (sq_busy_q) begin
				sq_cnt_q <= sq_cnt_q - 5'd1;
				if (sq_cnt_q == 5'd1) begin
					sq_busy_q <= 1'b0;
					sq_done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start && cmd.op == OP_SQRT) begin
			sq_v_q    <= sqx_q + sqy_q;
			sq_rem_q  <= '0;
			sq_root_q <= '0;
		end else if (sq_busy_q) begin
			sq_v_q <= {sq_v_q[29:0], 2'b00};
			if (sq_rem_sh >= sq_trial) begin
				sq_rem_q  <= sq_rem_sh - sq_trial;
				sq_root_q <= {sq_root_q[14:0], 1'b1};
			end else begin
				sq_rem_q  <= sq_rem_sh;
				sq_root_q <= {sq_root_q[14:0], 1'b0};
			end
		end
	end

	// Interval arithmetic
	assign score   = (mode_q == MODE_DENS) ? dens_q : comb_q;
	assign prod_sq = score * score;
	assign span    = max_q - min_q;
	assign prod_sc = fq_q * span;
	assign jit_mul = {1'b0, r_q} + 17'h08000;
	assign prod_j  = bi_q * jit_mul;

	// Item capture and score registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			now_q    <= now_t;
			newest_q <= newest_t;
			n_q      <= neighbor_count;
			vx_q     <= vel_x;
			vy_q     <= vel_y;
			r_q      <= random_fraction;
		end
		if (cmd.op == OP_SQUARE) begin
			sqx_q <= 32'(vx_q * vx_q);
			sqy_q <= 32'(vy_q * vy_q);
		end
		if (cmd.op == OP_DENS && dv_done_q)
			dens_q <= (n_q >= nthr_q) ? one_c : dv_num_q[QW-1:0];
		if (cmd.op == OP_CONT && dv_done_q)
			cont_q <= (n_q != 8'd0 && age_lt) ? dv_num_q[QW-1:0] : '0;
		if (cmd.op == OP_SQRT && sq_done_q)
			speed_q <= sq_root_q;
		if (cmd.op == OP_MOB && dv_done_q)
			mob_q <= (speed_q >= rspd_q) ? one_c : dv_num_q[QW-1:0];
		if (cmd.op == OP_COMB)
			comb_q <= prod_div[DK +: QW];
		if (cmd.op == OP_FQ)
			fq_q <= prod_sq[2*FRAC_BITS:FRAC_BITS];
		if (cmd.op == OP_SCALE)
			bi_q <= {1'b0, min_q} + prod_sc[FRAC_BITS+IV_W:FRAC_BITS];
		if (cmd.op == OP_JIT)
			jit_q <= prod_j[37:16];
	end

	// Clamp and send decision
	assign adaptive = (mode_q == MODE_DENS) || (mode_q == MODE_COMB);
	assign elapsed  = now_q - last_q;

	always_comb begin
		if (max_q <= min_q)
			interval = min_q;
		else if (jit_q > 22'(max_q))
			interval = max_q;
		else if (jit_q < 22'(min_q))
			interval = min_q;
		else
			interval = jit_q[IV_W-1:0];
	end

	always_comb begin
		send_c = 1'b0;
		next_c = wait_q;
		if (mode_q == MODE_STATIC) begin
			send_c = AW'(elapsed) > AW'(static_q);
			next_c = static_q;
		end else if (adaptive) begin
			send_c = AW'(elapsed) > AW'(wait_q);
			next_c = send_c ? interval : wait_q;
		end
	end

	// Configuration, state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_STATIC;
			min_q       <= RST_MIN_IV;
			max_q       <= RST_MAX_IV;
			static_q    <= RST_STATIC_IV;
			nthr_q      <= RST_NBR_THR;
			cthr_q      <= RST_CONT_THR;
			rspd_q      <= RST_REF_SPEED;
			wait_q      <= RST_FIRST_WAIT;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_MODE:       mode_q   <= cfg_data[1:0];
					CFG_MIN_IV:     min_q    <= cfg_data;
					CFG_MAX_IV:     max_q    <= cfg_data;
					CFG_STATIC_IV:  static_q <= cfg_data;
					CFG_NBR_THR:    nthr_q   <= cfg_data[7:0];
					CFG_CONT_THR:   cthr_q   <= cfg_data;
					CFG_REF_SPEED:  rspd_q   <= cfg_data[15:0];
					CFG_FIRST_WAIT: wait_q   <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.commit) begin
				if (send_c) last_q <= now_q;
				if (adaptive) wait_q <= next_c;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			send_q <= send_c;
			next_q <= next_c;
		end
	end

	assign out_valid  = out_valid_q;
	assign send_now   = send_q;
	assign next_check = next_q;

	assign status.div_done  = dv_done_q;
	assign status.sqrt_done = sq_done_q;
	assign status.out_free  = !out_valid_q || !out_stall;
	assign status.mode      = mode_q;

endmodule

FILE: hw/rtl/adaptive_beacon_scheduler.sv
// Top level of the adaptive beacon scheduler: sequencer plus datapath.
// Each accepted item is one beacon check; one result comes back per check, and one check
// is in flight at a time. In static mode or the unused mode a check passes only through
// its load and done steps. Density mode adds one pass of the shared restoring divider and
// the interval arithmetic steps (fq, scale, jitter). Combined mode runs the divider three
// times (density, contact, mobility) and the square root, and divides the weighted sum
// by ten with a reciprocal multiply. The divider yields one quotient bit per cycle. The
// next item is taken in the cycle after the result is loaded into the output register;
// while the output stays stalled with an older result, the check waits in its last step.
// Writing first_wait also reloads the stored wait.
module adaptive_beacon_scheduler #(
	parameter int TIME_BITS = abs_pkg::TIME_BITS_DEF,
	parameter int FRAC_BITS = abs_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [31:0]        now_time,
	input  logic [7:0]         neighbor_count,
	input  logic [31:0]        newest_contact,
	input  logic signed [15:0] vel_x,
	input  logic signed [15:0] vel_y,
	input  logic [15:0]        random_fraction,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               send_now,
	output logic [19:0]        next_check,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [19:0]        cfg_data
);
	import abs_pkg::*;

	abs_cmd_t    cmd;
	abs_status_t status;

	abs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	abs_datapath #(
		.TIME_BITS (TIME_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.now_time        (now_time),
		.neighbor_count  (neighbor_count),
		.newest_contact  (newest_contact),
		.vel_x           (vel_x),
		.vel_y           (vel_y),
		.random_fraction (random_fraction),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.send_now        (send_now),
		.next_check      (next_check)
	);

endmodule
